// File: design/rhpf_pkg.sv
// ----------------------------------------------------------------------------
// rhpf_pkg
// Shared constants, types and register indexes for the RGB 3x3 high-pass filter.
// ----------------------------------------------------------------------------
package rhpf_pkg;

  // Line store depth and derived widths
  localparam int MAX_ROW_PIXELS = 2048;
  localparam int COL_W          = $clog2(MAX_ROW_PIXELS);
  localparam int WEFF_W         = COL_W + 1;

  // Register and field widths
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 16;
  localparam int ROW_W      = HEIGHT_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CMP_W      = (WIDTH_W > WEFF_W) ? WIDTH_W : WEFF_W;

  localparam int CH_W   = 8;
  localparam int NUM_CH = 3;
  localparam int PIX_W  = NUM_CH * CH_W;
  localparam int TAPS   = 9;

  // Channel slots inside a packed pixel
  localparam int CH_RED   = 2;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 0;

  // Register reset values and lower limits
  localparam logic [WIDTH_W-1:0]  ROW_WIDTH_RST    = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] FRAME_HEIGHT_RST = HEIGHT_W'(480);
  localparam int                  MIN_DIM          = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_t;
  typedef pixel_t [TAPS-1:0]           window_t;
  typedef logic [TAPS-1:0][CH_W-1:0]   chan_win_t;

  // Output bookkeeping that travels with a pixel down the pipeline
  typedef struct packed {
    logic has_result;
    logic border;
    logic last;
  } out_ctl_t;

endpackage

// File: design/rhpf_line_buf.sv
// ----------------------------------------------------------------------------
// rhpf_line_buf
// Two row stores (upper and middle) with registered reads and a shared write.
// ----------------------------------------------------------------------------
module rhpf_line_buf (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [rhpf_pkg::COL_W-1:0] rd_addr,
  input  logic                  wr_en,
  input  logic [rhpf_pkg::COL_W-1:0] wr_addr,
  input  rhpf_pkg::pixel_t      wr_upper,
  input  rhpf_pkg::pixel_t      wr_middle,
  output rhpf_pkg::pixel_t      upper_rd,
  output rhpf_pkg::pixel_t      middle_rd
);
  import rhpf_pkg::*;

  pixel_t upper_mem  [MAX_ROW_PIXELS];
  pixel_t middle_mem [MAX_ROW_PIXELS];
  pixel_t upper_rd_r;
  pixel_t middle_rd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= wr_upper;
      middle_mem[wr_addr] <= wr_middle;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      upper_rd_r  <= upper_mem[rd_addr];
      middle_rd_r <= middle_mem[rd_addr];
    end
  end

  assign upper_rd  = upper_rd_r;
  assign middle_rd = middle_rd_r;

endmodule

// File: design/rhpf_lane.sv
// ----------------------------------------------------------------------------
// rhpf_lane
// One color channel of the sharpen kernel: 3x3 weighted sum, clamped to a byte.
// ----------------------------------------------------------------------------
module rhpf_lane (
  input  rhpf_pkg::chan_win_t        taps,
  output logic [rhpf_pkg::CH_W-1:0]  filt
);
  import rhpf_pkg::*;

  localparam int SUM_W = CH_W + 5;

  logic [CH_W+1:0]    corner_sum;
  logic [CH_W+1:0]    edge_sum;
  logic [CH_W+2:0]    center_x5;
  logic signed [SUM_W-1:0] total;

  // Kernel 1,-2,1 / -2,5,-2 / 1,-2,1: corners, edges and center
  always_comb begin
    corner_sum = (CH_W+2)'(taps[0]) + (CH_W+2)'(taps[2]) +
                 (CH_W+2)'(taps[6]) + (CH_W+2)'(taps[8]);
    edge_sum   = (CH_W+2)'(taps[1]) + (CH_W+2)'(taps[3]) +
                 (CH_W+2)'(taps[5]) + (CH_W+2)'(taps[7]);
    center_x5  = {taps[4], 2'b00} + (CH_W+3)'(taps[4]);
    total      = $signed(SUM_W'(corner_sum)) + $signed(SUM_W'(center_x5)) -
                 $signed(SUM_W'({edge_sum, 1'b0}));
    if (total < 0) begin
      filt = '0;
    end else if (total > $signed(SUM_W'({CH_W{1'b1}}))) begin
      filt = '1;
    end else begin
      filt = total[CH_W-1:0];
    end
  end

endmodule

// File: design/rhpf_merge.sv
// ----------------------------------------------------------------------------
// rhpf_merge
// Output stage: pick filtered or pass-through pixel, hold it until taken.
// ----------------------------------------------------------------------------
module rhpf_merge (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_vld,
  input  rhpf_pkg::out_ctl_t       ctl,
  input  rhpf_pkg::pixel_t         center,
  input  rhpf_pkg::pixel_t         filt,
  output logic                     advance,
  output logic                     out_valid,
  input  logic                     out_ready,
  output rhpf_pkg::pixel_t         out_pix,
  output logic                     out_last
);
  import rhpf_pkg::*;

  logic   out_valid_r;
  pixel_t out_pix_r;
  logic   out_last_r;

  // Pipeline moves whenever the output register is free or being emptied
  assign advance = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_vld && ctl.has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_pix_r  <= ctl.border ? center : filt;
      out_last_r <= ctl.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pix   = out_pix_r;
  assign out_last  = out_last_r;

endmodule

// File: design/rgb_high_pass_3x3_filter.sv
// ----------------------------------------------------------------------------
// rgb_high_pass_3x3_filter
// Streaming 3x3 sharpen filter on raster-order RGB pixels.
// ----------------------------------------------------------------------------
// The block takes one pixel transaction per clock and returns one result per
// clock at full rate; the output register decouples the two sides, so a
// stalled consumer only holds the pipeline when a result is already waiting.
// An accepted pixel passes the line store read, window update, kernel lanes
// and merge into the output register. Results trail the input stream
// by one row plus one pixel: after each frame send row_width_pixels + 1 flush
// transactions to drain the bottom row; frame_last marks the final result.
// Border rows and columns pass through; interior pixels get the kernel
// 1,-2,1 / -2,5,-2 / 1,-2,1 per channel, clamped to 0..255. Writing either
// configuration register restarts the stream at the top of a frame; write
// only while the block is idle. Widths outside 3..2048 and heights below 3
// are clamped. The line stores are not cleared after reset; entries are only
// ever read for border rows before they are written.
// ----------------------------------------------------------------------------
module rgb_high_pass_3x3_filter (
  input  logic                              clk,
  input  logic                              rst_n,
  // pixel input
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rhpf_pkg::CH_W-1:0]         in_red_in,
  input  logic [rhpf_pkg::CH_W-1:0]         in_green_in,
  input  logic [rhpf_pkg::CH_W-1:0]         in_blue_in,
  input  logic                              in_flush_tick,
  // result output
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rhpf_pkg::CH_W-1:0]         out_red_out,
  output logic [rhpf_pkg::CH_W-1:0]         out_green_out,
  output logic [rhpf_pkg::CH_W-1:0]         out_blue_out,
  output logic                              out_frame_last,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rhpf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rhpf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import rhpf_pkg::*;

  // Configuration and stream position
  logic [WIDTH_W-1:0]  row_width_r;
  logic [HEIGHT_W-1:0] frame_height_r;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;

  // Stage 0 decode
  logic [CMP_W-1:0]    w_ext;
  logic [WEFF_W-1:0]   w_eff;
  logic [COL_W-1:0]    w_last;
  logic [HEIGHT_W-1:0] h_eff;
  logic [ROW_W-1:0]    h_ext, h_last;
  logic [COL_W-1:0]    col_cur;
  logic [WEFF_W-1:0]   col_inc;
  logic                skip;
  logic                drain;
  pixel_t              px;
  logic [ROW_W-1:0]    orow;
  logic [COL_W-1:0]    ocol;
  out_ctl_t            ctl0;
  logic                accept;
  logic                advance;

  // Stage 1 (line store read data is registered alongside)
  logic                s1_vld_r;
  pixel_t              s1_px_r;
  logic [COL_W-1:0]    s1_col_r;
  logic                s1_wr_r;
  out_ctl_t            s1_ctl_r;
  pixel_t              upper_rd, middle_rd;

  // Stage 2: window and lanes
  window_t             window_r, window_nxt;
  logic                s2_vld_r;
  out_ctl_t            s2_ctl_r;
  pixel_t              filt;
  pixel_t              out_pix;

  assign cfg_ready = 1'b1;
  assign in_ready  = advance;
  assign accept    = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // Stage 0: clamp geometry, locate the pixel, decide what result it releases
  // --------------------------------------------------------------------------
  always_comb begin
    w_ext = CMP_W'(row_width_r);
    if (w_ext < CMP_W'(MIN_DIM)) begin
      w_eff = WEFF_W'(MIN_DIM);
    end else if (w_ext > CMP_W'(MAX_ROW_PIXELS)) begin
      w_eff = WEFF_W'(MAX_ROW_PIXELS);
    end else begin
      w_eff = WEFF_W'(w_ext);
    end
    w_last = COL_W'(w_eff - WEFF_W'(1));

    h_eff  = (frame_height_r < HEIGHT_W'(MIN_DIM)) ? HEIGHT_W'(MIN_DIM) : frame_height_r;
    h_ext  = ROW_W'(h_eff);
    h_last = h_ext - ROW_W'(1);

    col_cur = (WEFF_W'(col_r) >= w_eff) ? '0 : col_r;

    // A flush at the very start of a frame has nothing to drain: drop it
    skip  = in_flush_tick && (row_r == '0) && (col_cur == '0);
    drain = row_r >= h_ext;
    if (drain || in_flush_tick) begin
      px = '0;
    end else begin
      px[CH_RED]   = in_red_in;
      px[CH_GREEN] = in_green_in;
      px[CH_BLUE]  = in_blue_in;
    end

    // The window center is one row and one column behind the input
    if (col_cur != '0) begin
      ctl0.has_result = row_r != '0;
      orow            = row_r - ROW_W'(1);
      ocol            = col_cur - COL_W'(1);
    end else begin
      ctl0.has_result = row_r >= ROW_W'(2);
      orow            = row_r - ROW_W'(2);
      ocol            = w_last;
    end
    if (orow >= h_ext) begin
      ctl0.has_result = 1'b0;
    end
    ctl0.border = (orow == '0) || (orow == h_last) || (ocol == '0) || (ocol == w_last);
    ctl0.last   = (orow == h_last) && (ocol == w_last);

    // Advance the raster position; restart after the frame's final result
    col_inc = WEFF_W'(col_cur) + WEFF_W'(1);
    if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = row_r + ROW_W'(1);
    end else begin
      col_nxt = COL_W'(col_inc);
      row_nxt = row_r;
    end
    if (ctl0.has_result && ctl0.last) begin
      col_nxt = '0;
      row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r    <= ROW_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      col_r          <= '0;
      row_r          <= '0;
    end else if (cfg_valid && cfg_ready) begin
      // A register write restarts the frame; unknown indexes are dropped
      case (cfg_index)
        REG_ROW_WIDTH: begin
          row_width_r <= cfg_wdata[WIDTH_W-1:0];
          col_r       <= '0;
          row_r       <= '0;
        end
        REG_FRAME_HEIGHT: begin
          frame_height_r <= cfg_wdata[HEIGHT_W-1:0];
          col_r          <= '0;
          row_r          <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept && !skip) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: line stores. Read the column on acceptance, write it back when the
  // pipeline next advances; consecutive writes never share a column.
  // --------------------------------------------------------------------------
  rhpf_line_buf u_line_buf (
    .clk       (clk),
    .rd_en     (advance),
    .rd_addr   (col_cur),
    .wr_en     (advance && s1_vld_r && s1_wr_r),
    .wr_addr   (s1_col_r),
    .wr_upper  (middle_rd),
    .wr_middle (s1_px_r),
    .upper_rd  (upper_rd),
    .middle_rd (middle_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (advance) begin
      s1_vld_r <= accept && !skip;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_px_r  <= px;
      s1_col_r <= col_cur;
      s1_wr_r  <= !drain;
      s1_ctl_r <= ctl0;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: slide the window left by one column and insert the new column
  // --------------------------------------------------------------------------
  always_comb begin
    window_nxt = window_r;
    for (int y = 0; y < 3; y++) begin
      window_nxt[y*3]     = window_r[y*3 + 1];
      window_nxt[y*3 + 1] = window_r[y*3 + 2];
    end
    window_nxt[2] = upper_rd;
    window_nxt[5] = middle_rd;
    window_nxt[8] = s1_px_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      s2_vld_r <= 1'b0;
    end else if (advance) begin
      s2_vld_r <= s1_vld_r;
      if (s1_vld_r) begin
        window_r <= window_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_ctl_r <= s1_ctl_r;
    end
  end

  // One kernel lane per color channel
  for (genvar k = 0; k < NUM_CH; k++) begin : g_lane
    chan_win_t taps;
    always_comb begin
      for (int t = 0; t < TAPS; t++) begin
        taps[t] = window_r[t][k];
      end
    end
    rhpf_lane u_lane (
      .taps (taps),
      .filt (filt[k])
    );
  end

  // --------------------------------------------------------------------------
  // Stage 3: merge lanes with the pass-through center into the output register
  // --------------------------------------------------------------------------
  rhpf_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (s2_vld_r),
    .ctl       (s2_ctl_r),
    .center    (window_r[4]),
    .filt      (filt),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_pix   (out_pix),
    .out_last  (out_frame_last)
  );

  assign out_red_out   = out_pix[CH_RED];
  assign out_green_out = out_pix[CH_GREEN];
  assign out_blue_out  = out_pix[CH_BLUE];

endmodule
